// ----- hw/rtl/drfp_pkg.sv -----
// drfp_pkg: types and constants of the display reply frame parser.
// Used by the classifier and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package drfp_pkg;

    localparam int unsigned HEAD_DEPTH = 7;

    localparam logic [7:0] TERM_BYTE       = 8'hFF;
    localparam logic [7:0] PAGE_EVENT_CODE = 8'h65;
    localparam logic [7:0] DIGIT_ZERO      = 8'h30;
    // run value held before the closing terminator byte
    localparam logic [1:0] TERM_RUN_LAST   = 2'd2;

    localparam logic       REQ_BYTE       = 1'b0;
    localparam logic       REQ_LINE_ERROR = 1'b1;

    localparam logic [1:0] KIND_UNKNOWN    = 2'd0;
    localparam logic [1:0] KIND_PAGE_EVENT = 2'd1;
    localparam logic [1:0] KIND_PAGE_CMD   = 2'd2;
    localparam logic [1:0] KIND_REFRESH    = 2'd3;

    typedef logic [HEAD_DEPTH-1:0][7:0] t_head;

    // "page=", byte 0 in the low lane
    localparam logic [4:0][7:0] PAGE_CMD_TEXT =
        {8'h3D, 8'h65, 8'h67, 8'h61, 8'h70};
    // "refresh", byte 0 in the low lane
    localparam t_head REFRESH_TEXT =
        {8'h68, 8'h73, 8'h65, 8'h72, 8'h66, 8'h65, 8'h72};

    typedef struct packed {
        logic ge3;
        logic ge6;
        logic ge7;
    } t_len_flags;

    typedef struct packed {
        logic [1:0] kind;
        logic       page_upd;
        logic [7:0] new_page;
        logic       inval;
        logic       refresh;
    } t_class;

endpackage

`default_nettype wire

// ----- hw/rtl/drfp_in_if.sv -----
// drfp_in_if: input channel of the frame parser (request type and byte).
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface drfp_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/drfp_out_if.sv -----
// drfp_out_if: result channel of the frame parser.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface drfp_out_if;
    logic       valid;
    logic       ready;
    logic       frame_done;
    logic [1:0] frame_kind;
    logic [7:0] current_page;
    logic       invalidate_cache;
    logic       refresh_request;

    modport source (
        output valid, output frame_done, output frame_kind, output current_page,
        output invalidate_cache, output refresh_request, input ready
    );
    modport sink (
        input valid, input frame_done, input frame_kind, input current_page,
        input invalidate_cache, input refresh_request, output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/drfp_classify.sv -----
// drfp_classify: decodes the head bytes of a closed frame into its kind.
// Depends on drfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module drfp_classify (
    input  var drfp_pkg::t_head      i_head,
    input  var drfp_pkg::t_len_flags i_len,
    input  var logic [7:0]           i_page,
    output var drfp_pkg::t_class     o_class
);

    logic       is_event;
    logic       is_cmd;
    logic       is_refresh;
    logic [7:0] cmd_page;

    always_comb begin
        is_event   = i_len.ge3 && (i_head[0] == drfp_pkg::PAGE_EVENT_CODE);
        is_cmd     = i_len.ge6 && (i_head[4:0] == drfp_pkg::PAGE_CMD_TEXT);
        is_refresh = i_len.ge7 && (i_head == drfp_pkg::REFRESH_TEXT);
        cmd_page   = i_head[5] - drfp_pkg::DIGIT_ZERO;

        o_class = '0;
        if (is_event) begin
            o_class.kind     = drfp_pkg::KIND_PAGE_EVENT;
            o_class.page_upd = 1'b1;
            o_class.new_page = i_head[1];
            o_class.inval    = (i_head[1] != i_page);
            o_class.refresh  = 1'b1;
        end else if (is_cmd) begin
            o_class.kind     = drfp_pkg::KIND_PAGE_CMD;
            o_class.page_upd = 1'b1;
            o_class.new_page = cmd_page;
            o_class.inval    = (cmd_page != i_page);
            o_class.refresh  = 1'b1;
        end else if (is_refresh) begin
            o_class.kind     = drfp_pkg::KIND_REFRESH;
            o_class.new_page = i_page;
            o_class.inval    = 1'b1;
            o_class.refresh  = 1'b1;
        end else begin
            o_class.kind     = drfp_pkg::KIND_UNKNOWN;
            o_class.new_page = i_page;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/display_reply_frame_parser.sv -----
// display_reply_frame_parser: frame parser for the reply stream of a display link.
// Depends on drfp_pkg, drfp_in_if, drfp_out_if and drfp_classify.
//
// Usage:
//   i_in  carries one transfer per received byte (req_type 0) or line error
//         (req_type 1). Frames end with three 0xFF bytes; lone 0xFF bytes are
//         not stored. A byte arriving with BUF_DEPTH bytes held clears the frame.
//   o_out carries exactly one result transfer per input transfer: frame_done,
//         frame_kind, the page held after the item, and cache/redraw flags.
//   Timing: the result is registered and valid in the cycle after its input transfer.
//   Throughput: one item per cycle unless o_out stalls. The frame state and the
//         classifier feed a single result register; nothing loops over cycles.
//   Stall: i_in.ready = !result_valid || o_out.ready, so a new item is taken
//         in the same cycle as the waiting result is taken. While the receiver
//         stalls, the result register and i_in.ready hold.
//   Reset (i_rst_n low, synchronous): frame length, 0xFF run, page and the
//         result valid flag clear. Head bytes hold no reset; only bytes written
//         in the current frame are ever decoded.
`timescale 1ns / 1ps
`default_nettype none

module display_reply_frame_parser #(
    parameter int unsigned BUF_DEPTH = 64
) (
    input  var logic     i_clk,
    input  var logic     i_rst_n,
    drfp_in_if.sink      i_in,
    drfp_out_if.source   o_out
);

    localparam int unsigned LEN_W = $clog2(BUF_DEPTH + 1);

    // frame state
    drfp_pkg::t_head  r_head;
    logic [LEN_W-1:0] r_len, n_len;
    logic [1:0]       r_run, n_run;
    logic [7:0]       r_page, n_page;

    // result register
    logic       r_out_valid;
    logic       r_done, n_done;
    logic [1:0] r_kind, n_kind;
    logic       r_inval, n_inval;
    logic       r_refresh, n_refresh;

    logic accept;
    logic head_wr;

    drfp_pkg::t_len_flags len_flags;
    drfp_pkg::t_class     cls;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    assign len_flags.ge3 = (r_len >= LEN_W'(3));
    assign len_flags.ge6 = (r_len >= LEN_W'(6));
    assign len_flags.ge7 = (r_len >= LEN_W'(drfp_pkg::HEAD_DEPTH));

    // classifier sees the bytes stored so far; a closing 0xFF writes nothing
    drfp_classify u_classify (
        .i_head  (r_head),
        .i_len   (len_flags),
        .i_page  (r_page),
        .o_class (cls)
    );

    always_comb begin
        n_len     = r_len;
        n_run     = r_run;
        n_page    = r_page;
        n_done    = 1'b0;
        n_kind    = drfp_pkg::KIND_UNKNOWN;
        n_inval   = 1'b0;
        n_refresh = 1'b0;
        head_wr   = 1'b0;

        if (i_in.req_type == drfp_pkg::REQ_LINE_ERROR) begin
            n_len = '0;
            n_run = '0;
        end else if (i_in.rx_byte == drfp_pkg::TERM_BYTE) begin
            if (r_run == drfp_pkg::TERM_RUN_LAST) begin
                // third 0xFF: close the frame, empty frames give no flags
                if (r_len != '0) begin
                    n_done    = 1'b1;
                    n_kind    = cls.kind;
                    n_inval   = cls.inval;
                    n_refresh = cls.refresh;
                    if (cls.page_upd) begin
                        n_page = cls.new_page;
                    end
                end
                n_len = '0;
                n_run = '0;
            end else begin
                n_run = r_run + 2'd1;
            end
        end else begin
            n_run = '0;
            if (r_len < LEN_W'(BUF_DEPTH)) begin
                head_wr = (r_len < LEN_W'(drfp_pkg::HEAD_DEPTH));
                n_len   = r_len + LEN_W'(1);
            end else begin
                // overflow: drop the byte and the frame
                n_len = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_run       <= '0;
            r_page      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_len  <= n_len;
                r_run  <= n_run;
                r_page <= n_page;
            end
            if (i_in.ready) begin
                r_out_valid <= i_in.valid;
            end
        end
    end

    // head bytes: each lane written only at its own position
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < drfp_pkg::HEAD_DEPTH; i++) begin
            if (accept && head_wr && (r_len == LEN_W'(i))) begin
                r_head[i] <= i_in.rx_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_done    <= n_done;
            r_kind    <= n_kind;
            r_inval   <= n_inval;
            r_refresh <= n_refresh;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.frame_done       = r_done;
    assign o_out.frame_kind       = r_kind;
    assign o_out.current_page     = r_page;
    assign o_out.invalidate_cache = r_inval;
    assign o_out.refresh_request  = r_refresh;

`ifndef ASSERT_OFF
    a_len_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(BUF_DEPTH))
        else $error("frame length beyond buffer depth");

    a_run_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run != 2'd3)
        else $error("terminator run reached three without closing");

    a_flags_need_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_done) |->
            (r_kind == drfp_pkg::KIND_UNKNOWN && !r_inval && !r_refresh))
        else $error("result flags set without a closed frame");

    a_line_error_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.req_type == drfp_pkg::REQ_LINE_ERROR) |=>
            (r_len == '0 && r_run == '0 && !r_done))
        else $error("line error did not clear the frame");
`endif

endmodule

`default_nettype wire
